// ----- sv/skt_pkg.sv -----
// ============================================================================
// SQL keyword tokenizer package
// Shared types, constants and character/keyword helper functions.
// ============================================================================
package skt_pkg;

    // Field widths fixed by the token format.
    localparam int START_W = 16;
    localparam int LEN_W   = 17;

    // Default statement size limit.
    localparam int MAX_STMT_BYTES_DEFAULT = 65536;

    // Tokens that one input beat can produce at most, and queue depth in groups.
    localparam int GRP_TOKENS     = 3;
    localparam int GRP_FIFO_DEPTH = 4;

    // Keyword slots in the candidate mask.
    localparam int KW_SELECT = 0;
    localparam int KW_FROM   = 1;
    localparam int KW_WHERE  = 2;
    localparam int KW_OR     = 3;
    localparam int KW_AND    = 4;
    localparam int KW_COUNT  = 5;

    // Character codes.
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0   = 8'h30;
    localparam logic [7:0] CH_DIGIT_9   = 8'h39;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_EQ        = 8'h3D;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef enum logic [3:0] {
        TK_END    = 4'd0,
        TK_SELECT = 4'd1,
        TK_FROM   = 4'd2,
        TK_WHERE  = 4'd3,
        TK_OR     = 4'd4,
        TK_AND    = 4'd5,
        TK_IDENT  = 4'd6,
        TK_NUMBER = 4'd7,
        TK_EQ     = 4'd8,
        TK_GT     = 4'd9,
        TK_LT     = 4'd10,
        TK_LPAREN = 4'd11,
        TK_RPAREN = 4'd12,
        TK_COMMA  = 4'd13,
        TK_STAR   = 4'd14
    } token_kind_t;

    // Input beat payload.
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] char_byte;
        logic       end_of_statement;
    } in_beat_t;

    // Output beat payload.
    typedef struct packed {
        token_kind_t          token_kind;
        logic [START_W-1:0]   token_start;
        logic [LEN_W-1:0]     token_length;
        logic                 last_of_run;
    } token_t;

    // All tokens caused by one input beat.
    typedef struct packed {
        logic [1:0]                   count;
        token_t [GRP_TOKENS-1:0]      tok;
    } grp_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    endfunction

    function automatic logic [7:0] to_upper(logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ? c - CASE_OFFSET : c;
    endfunction

    function automatic logic [2:0] kw_len(int idx);
        logic [2:0] len;
        unique case (idx)
            KW_SELECT: len = 3'd6;
            KW_FROM:   len = 3'd4;
            KW_WHERE:  len = 3'd5;
            KW_OR:     len = 3'd2;
            KW_AND:    len = 3'd3;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic token_kind_t kw_kind(int idx);
        token_kind_t k;
        unique case (idx)
            KW_SELECT: k = TK_SELECT;
            KW_FROM:   k = TK_FROM;
            KW_WHERE:  k = TK_WHERE;
            KW_OR:     k = TK_OR;
            KW_AND:    k = TK_AND;
            default:   k = TK_IDENT;
        endcase
        return k;
    endfunction

    // Keyword text, one upper-case character per position.
    function automatic logic [7:0] kw_char(int idx, logic [2:0] p);
        logic [47:0] text;
        unique case (idx)
            KW_SELECT: text = "SELECT";
            KW_FROM:   text = {"FROM", 16'h0};
            KW_WHERE:  text = {"WHERE", 8'h0};
            KW_OR:     text = {"OR", 32'h0};
            KW_AND:    text = {"AND", 24'h0};
            default:   text = '0;
        endcase
        return text[(3'd5 - p) * 8 +: 8];
    endfunction

    // Narrow the keyword candidate mask with the byte at word offset pos.
    function automatic logic [KW_COUNT-1:0] kw_match(logic [KW_COUNT-1:0] cand,
                                                     logic [7:0] c,
                                                     logic [LEN_W-1:0] pos);
        logic [KW_COUNT-1:0] keep;
        logic [7:0]          u;
        keep = '0;
        u    = to_upper(c);
        for (int i = 0; i < KW_COUNT; i++) begin
            if (cand[i] && (pos < LEN_W'(kw_len(i))) && (kw_char(i, pos[2:0]) == u)) begin
                keep[i] = 1'b1;
            end
        end
        return keep;
    endfunction

    // Single-byte symbol kind; TK_END when the byte is no symbol.
    function automatic token_kind_t sym_kind(logic [7:0] c);
        token_kind_t k;
        unique case (c)
            CH_EQ:     k = TK_EQ;
            CH_GT:     k = TK_GT;
            CH_LT:     k = TK_LT;
            CH_LPAREN: k = TK_LPAREN;
            CH_RPAREN: k = TK_RPAREN;
            CH_COMMA:  k = TK_COMMA;
            CH_STAR:   k = TK_STAR;
            default:   k = TK_END;
        endcase
        return k;
    endfunction

endpackage

// ----- sv/skt_stream_if.sv -----
// ============================================================================
// Stream channel interface
// Valid/ready channel carrying one payload beat per handshake.
// ============================================================================
interface skt_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/skt_front.sv -----
// ============================================================================
// Tokenizer front end
// Classifies each byte, updates the scan state and builds the token group.
// ============================================================================
module skt_front #(
    parameter int MAX_STATEMENT_BYTES = skt_pkg::MAX_STMT_BYTES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    skt_stream_if.sink         chars,
    input  skt_pkg::fifo_stat_t stat,
    output logic               push,
    output skt_pkg::grp_t      grp
);
    import skt_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM
    } mode_t;

    localparam int LEN_LIM_INT   = (MAX_STATEMENT_BYTES < 131071) ? MAX_STATEMENT_BYTES : 131071;
    localparam int START_LIM_INT = ((MAX_STATEMENT_BYTES - 1) < 65535) ?
                                   (MAX_STATEMENT_BYTES - 1) : 65535;
    localparam logic [LEN_W-1:0] LEN_LIM   = LEN_LIM_INT[LEN_W-1:0];
    localparam logic [LEN_W-1:0] START_LIM = START_LIM_INT[LEN_W-1:0];

    mode_t               mode_reg, mode_next;
    logic [LEN_W-1:0]    pos_reg, pos_next;
    logic [START_W-1:0]  ostart_reg, ostart_next;
    logic [LEN_W-1:0]    olen_reg, olen_next;
    logic [KW_COUNT-1:0] cand_reg, cand_next;

    logic                accept;
    logic [7:0]          c;
    logic                c_letter;
    logic                c_digit;
    logic                c_word_first;
    logic                c_word_cont;
    token_kind_t         c_sym;
    logic [LEN_W-1:0]    pos_inc;
    token_t [GRP_TOKENS-1:0] toks;
    logic [1:0]          n;

    // Clamp a position to the largest start offset.
    function automatic logic [START_W-1:0] clamp_start(logic [LEN_W-1:0] p);
        return (p < START_LIM) ? p[START_W-1:0] : START_LIM[START_W-1:0];
    endfunction

    // Token for the open word or number.
    function automatic token_t close_tok(mode_t m, logic [KW_COUNT-1:0] cand,
                                         logic [START_W-1:0] st, logic [LEN_W-1:0] ln);
        token_t t;
        t.token_kind   = (m == MODE_WORD) ? TK_IDENT : TK_NUMBER;
        t.token_start  = st;
        t.token_length = ln;
        t.last_of_run  = 1'b0;
        if (m == MODE_WORD) begin
            for (int i = KW_COUNT - 1; i >= 0; i--) begin
                if (cand[i] && (ln == LEN_W'(kw_len(i)))) begin
                    t.token_kind = kw_kind(i);
                end
            end
        end
        return t;
    endfunction

    // Byte classification.
    assign c            = chars.payload.char_byte;
    assign c_letter     = is_letter(c);
    assign c_digit      = is_digit(c);
    assign c_word_first = c_letter || (c == CH_UNDERSCORE);
    assign c_word_cont  = c_word_first || c_digit;
    assign c_sym        = sym_kind(c);
    assign pos_inc      = (pos_reg < LEN_LIM) ? pos_reg + 1'b1 : pos_reg;

    assign chars.ready = !stat.full;
    assign accept      = chars.valid && chars.ready;

    // Scan state update and token group assembly.
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        ostart_next = ostart_reg;
        olen_next   = olen_reg;
        cand_next   = cand_reg;
        toks        = '0;
        n           = '0;

        if (accept) begin
            if (chars.payload.byte_valid) begin
                if (((mode_reg == MODE_WORD) && c_word_cont) ||
                    ((mode_reg == MODE_NUM) && c_digit)) begin
                    // The open token goes on.
                    if (mode_reg == MODE_WORD) begin
                        cand_next = kw_match(cand_reg, c, olen_reg);
                    end
                    olen_next = (olen_reg < LEN_LIM) ? olen_reg + 1'b1 : olen_reg;
                end else begin
                    if (mode_reg != MODE_IDLE) begin
                        toks[n] = close_tok(mode_reg, cand_reg, ostart_reg, olen_reg);
                        n       = n + 2'd1;
                    end
                    mode_next = MODE_IDLE;
                    olen_next = '0;
                    cand_next = '0;
                    if (c_word_first) begin
                        mode_next   = MODE_WORD;
                        ostart_next = clamp_start(pos_reg);
                        cand_next   = kw_match('1, c, '0);
                        olen_next   = LEN_W'(1);
                    end else if (c_digit) begin
                        mode_next   = MODE_NUM;
                        ostart_next = clamp_start(pos_reg);
                        olen_next   = LEN_W'(1);
                    end else if (c_sym != TK_END) begin
                        toks[n].token_kind   = c_sym;
                        toks[n].token_start  = clamp_start(pos_reg);
                        toks[n].token_length = LEN_W'(1);
                        n = n + 2'd1;
                    end
                end
                pos_next = pos_inc;
            end

            // End of statement flushes the open token, adds END and restarts.
            if (chars.payload.end_of_statement) begin
                if (mode_next != MODE_IDLE) begin
                    toks[n] = close_tok(mode_next, cand_next, ostart_next, olen_next);
                    n       = n + 2'd1;
                end
                toks[n].token_kind   = TK_END;
                toks[n].token_start  = clamp_start(pos_next);
                toks[n].token_length = '0;
                n = n + 2'd1;
                mode_next   = MODE_IDLE;
                pos_next    = '0;
                ostart_next = '0;
                olen_next   = '0;
                cand_next   = '0;
            end

            if (n != 2'd0) begin
                toks[n - 2'd1].last_of_run = 1'b1;
            end
        end
    end

    assign push      = accept && (n != 2'd0);
    assign grp.count = n;
    assign grp.tok   = toks;

    // Scan state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            ostart_reg <= '0;
            olen_reg   <= '0;
            cand_reg   <= '0;
        end else begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            ostart_reg <= ostart_next;
            olen_reg   <= olen_next;
            cand_reg   <= cand_next;
        end
    end

endmodule

// ----- sv/skt_grp_fifo.sv -----
// ============================================================================
// Token group queue
// Short queue of token groups between the front end and the back end.
// ============================================================================
module skt_grp_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  skt_pkg::grp_t       wr_grp,
    input  logic                pop,
    output skt_pkg::grp_t       head,
    output skt_pkg::fifo_stat_t stat
);
    import skt_pkg::*;

    localparam int PTR_W = $clog2(GRP_FIFO_DEPTH);
    localparam int CNT_W = $clog2(GRP_FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = GRP_FIFO_DEPTH[CNT_W-1:0];

    grp_t             mem [GRP_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == DEPTH_CNT);
    assign stat.empty = (cnt_reg == '0);
    assign head       = mem[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Group storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_grp;
        end
    end

endmodule

// ----- sv/skt_back.sv -----
// ============================================================================
// Tokenizer back end
// Walks the head token group and sends one token beat per cycle while the sink is ready and the queue is not empty.
// ============================================================================
module skt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  skt_pkg::grp_t       head,
    input  skt_pkg::fifo_stat_t stat,
    output logic                pop,
    skt_stream_if.source        tokens
);
    import skt_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    token_t     tok_reg, tok_next;
    logic       load;
    logic       last;

    // Load the output register whenever the queue holds a group and the register is empty or being drained.
    assign load = !stat.empty && (!out_valid_reg || tokens.ready);
    assign last = (idx_reg == (head.count - 2'd1));
    assign pop  = load && last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        tok_next       = tok_reg;
        if (load) begin
            tok_next       = head.tok[idx_reg];
            out_valid_next = 1'b1;
            idx_next       = last ? 2'd0 : idx_reg + 2'd1;
        end else if (tokens.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign tokens.valid   = out_valid_reg;
    assign tokens.payload = tok_reg;

endmodule

// ----- sv/sql_keyword_tokenizer_unit.sv -----
// ============================================================================
// SQL keyword tokenizer
// Byte-per-beat SQL lexer with keyword match, emitting kind/start/length tokens.
// ============================================================================
// Throughput: one input byte per cycle while the group queue has room.
// Output: one token per cycle while ready; a byte's k tokens go out in turn.
// Each token is registered in the group queue, then in the output register.
// The queue holds four groups, which sets how long the input rides out a stall.
// Reset clears the scan state, the queue and the output valid.
module sql_keyword_tokenizer_unit #(
    parameter int MAX_STATEMENT_BYTES = skt_pkg::MAX_STMT_BYTES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    skt_stream_if.sink   chars,
    skt_stream_if.source tokens
);
    import skt_pkg::*;

    logic       grp_push;
    logic       grp_pop;
    grp_t       wr_grp;
    grp_t       head_grp;
    fifo_stat_t stat;

    skt_front #(
        .MAX_STATEMENT_BYTES(MAX_STATEMENT_BYTES)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .stat  (stat),
        .push  (grp_push),
        .grp   (wr_grp)
    );

    skt_grp_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (grp_push),
        .wr_grp (wr_grp),
        .pop    (grp_pop),
        .head   (head_grp),
        .stat   (stat)
    );

    skt_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head_grp),
        .stat   (stat),
        .pop    (grp_pop),
        .tokens (tokens)
    );

    // The front end never writes a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) grp_push |-> !stat.full)
        else $error("token group pushed into a full queue");

    // The back end never takes from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) grp_pop |-> !stat.empty)
        else $error("token group popped from an empty queue");

    // An END token is always zero length and closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && (tokens.payload.token_kind == TK_END)) |->
        (tokens.payload.last_of_run && (tokens.payload.token_length == '0)))
        else $error("END token with nonzero length or not last of run");

    // A bare beat with neither byte nor end mark produces no tokens.
    assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && chars.ready && !chars.payload.byte_valid &&
         !chars.payload.end_of_statement) |-> !grp_push)
        else $error("bare beat produced a token group");

endmodule
